### sv/isort_pkg.sv
// Shared types for the integer list sorter: element type and the per-cycle
// control word that drives every cell of the insertion chain. No dependencies.
`default_nettype none

package isort_pkg;

    localparam int ELEM_W = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;

    // insert: place the arriving element in order
    // shift_lo: every cell takes its upper neighbor (drain from the low end)
    // shift_hi: every cell takes its lower neighbor (drain from the high end)
    typedef struct packed {
        logic insert;
        logic shift_lo;
        logic shift_hi;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/isort_cell.sv
// One slot of the insertion chain: holds an element and its valid bit and
// trades data with its two neighbors. Depends on isort_pkg.
`default_nettype none

module isort_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire isort_pkg::cell_ctrl_t ctrl,
    input  wire isort_pkg::elem_t     new_val,
    input  wire isort_pkg::elem_t     lo_val,
    input  wire logic                 lo_valid,
    input  wire logic                 lo_ins,
    input  wire isort_pkg::elem_t     hi_val,
    input  wire logic                 hi_valid,
    output isort_pkg::elem_t          val,
    output logic                      valid,
    output logic                      ins
);

    isort_pkg::elem_t val_reg, val_next;
    logic             valid_reg, valid_next;

    // Chain is kept ascending; empty cells behave as +infinity.
    assign ins   = !valid_reg || (new_val < val_reg);
    assign val   = val_reg;
    assign valid = valid_reg;

    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.insert) begin
            if (ins) begin
                if (lo_ins) begin
                    val_next   = lo_val;
                    valid_next = lo_valid;
                end else begin
                    val_next   = new_val;
                    valid_next = 1'b1;
                end
            end
        end else if (ctrl.shift_lo) begin
            val_next   = hi_val;
            valid_next = hi_valid;
        end else if (ctrl.shift_hi) begin
            val_next   = lo_val;
            valid_next = lo_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

### sv/integer_list_sorter.sv
// Integer list sorter top level: a chain of MAX_COUNT isort_cell slots plus
// load, drain and output control. Depends on isort_pkg and isort_cell.
//
// Loading takes one input transfer per cycle: each arriving value is placed in
// sorted position along the cell chain in the cycle it is accepted. The
// transfer carrying last closes the list; the input then stalls while the
// chain drains. An ascending list leaves from the low end of the chain at one
// result per cycle while m_ready does not stall the output. A descending list
// leaves from the high end, so its results follow the empty shifts that move
// the filled cells up to the head. The next list may start loading as soon as
// the final result sits in the output register. Values beyond MAX_COUNT are
// discarded and every result of that list carries dropped. The order
// register may be written at any time; it is sampled when a list closes.
`default_nettype none

module integer_list_sorter #(
    parameter int MAX_COUNT = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_descending,
    // input list
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire isort_pkg::elem_t s_value,
    input  wire logic             s_last,
    // sorted results
    output logic                  m_valid,
    input  wire logic             m_ready,
    output isort_pkg::elem_t      m_value_res,
    output logic                  m_last_res,
    output logic                  m_dropped
);

    localparam int CW = $clog2(MAX_COUNT + 1);

    logic [CW-1:0]    count_reg, rem_reg;
    logic             ovf_reg, desc_reg;
    logic             drain_reg, drain_desc_reg, drop_reg;
    logic             m_valid_reg, m_last_reg, m_dropped_reg;
    isort_pkg::elem_t m_value_reg;

    isort_pkg::elem_t      cell_val   [MAX_COUNT];
    logic [MAX_COUNT-1:0]  cell_valid;
    logic [MAX_COUNT-1:0]  cell_ins;
    isort_pkg::cell_ctrl_t ctrl;

    logic             s_fire, close, full, out_free, head_valid, pop, step;
    isort_pkg::elem_t head_val;

    assign cfg_ready = 1'b1;
    assign s_ready   = !drain_reg;
    assign s_fire    = s_valid && s_ready;
    assign close     = s_fire && s_last;
    assign full      = (count_reg == CW'(MAX_COUNT));

    assign head_valid = drain_desc_reg ? cell_valid[MAX_COUNT-1] : cell_valid[0];
    assign head_val   = drain_desc_reg ? cell_val[MAX_COUNT-1]   : cell_val[0];
    assign out_free   = !m_valid_reg || m_ready;
    assign pop        = drain_reg && head_valid && out_free;
    // empty head slots in a descending drain are shifted past without a result
    assign step       = drain_reg && (pop || !head_valid);

    assign ctrl.insert   = s_fire && !full;
    assign ctrl.shift_lo = step && !drain_desc_reg;
    assign ctrl.shift_hi = step && drain_desc_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_COUNT; gi++) begin : g_cell
            isort_pkg::elem_t lo_val, hi_val;
            logic             lo_valid, lo_ins, hi_valid;
            if (gi == 0) begin : g_lo_edge
                assign lo_val   = '0;
                assign lo_valid = 1'b0;
                assign lo_ins   = 1'b0;
            end else begin : g_lo_nbr
                assign lo_val   = cell_val[gi-1];
                assign lo_valid = cell_valid[gi-1];
                assign lo_ins   = cell_ins[gi-1];
            end
            if (gi == MAX_COUNT - 1) begin : g_hi_edge
                assign hi_val   = '0;
                assign hi_valid = 1'b0;
            end else begin : g_hi_nbr
                assign hi_val   = cell_val[gi+1];
                assign hi_valid = cell_valid[gi+1];
            end
            isort_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .new_val  (s_value),
                .lo_val   (lo_val),
                .lo_valid (lo_valid),
                .lo_ins   (lo_ins),
                .hi_val   (hi_val),
                .hi_valid (hi_valid),
                .val      (cell_val[gi]),
                .valid    (cell_valid[gi]),
                .ins      (cell_ins[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            desc_reg <= cfg_descending;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            drain_reg      <= 1'b0;
            drain_desc_reg <= 1'b0;
            drop_reg       <= 1'b0;
            rem_reg        <= '0;
        end else begin
            if (close) begin
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
                drain_reg      <= 1'b1;
                drain_desc_reg <= desc_reg;
                drop_reg       <= ovf_reg || full;
                rem_reg        <= full ? count_reg : count_reg + CW'(1);
            end else if (s_fire) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (pop) begin
                rem_reg <= rem_reg - CW'(1);
                if (rem_reg == CW'(1)) begin
                    drain_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_value_reg   <= head_val;
            m_last_reg    <= (rem_reg == CW'(1));
            m_dropped_reg <= drop_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value_res = m_value_reg;
    assign m_last_res  = m_last_reg;
    assign m_dropped   = m_dropped_reg;

`ifndef NO_ASSERTIONS
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        !drain_reg |-> (CW'($countones(cell_valid)) == count_reg))
        else $error("occupied cells disagree with element count");

    a_asc_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_reg && !drain_desc_reg) |-> cell_valid[0])
        else $error("ascending drain found an empty head cell");

    a_chain_empty_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && rem_reg == CW'(1)) |=> (cell_valid == '0))
        else $error("cells still occupied after final result");

    a_remaining_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> (CW'($countones(cell_valid)) == rem_reg))
        else $error("remaining count disagrees with occupied cells");
`endif

endmodule

`default_nettype wire
